>>> design/modulated_delay_line_assert.svh
// assertion macros for the modulated delay line
`ifndef MODULATED_DELAY_LINE_ASSERT_SVH
`define MODULATED_DELAY_LINE_ASSERT_SVH

`ifndef SYNTHESIS
`define MDL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdl check failed");
`define MDL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdl check failed");
`else
`define MDL_ASSERT_IMP(lbl, ante, cons)
`define MDL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> design/mdl_pkg.sv
package mdl_pkg;

    localparam int LINE_SIZE_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int BASE_W     = 11;
    localparam int PERIOD_W   = 16;
    localparam int DEPTH_W    = 8;
    localparam int OFFS_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH  = 2'd2;

    localparam int OUTQ_DEPTH = 3;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 2;

endpackage

>>> design/mdl_mod.sv
module mdl_mod
    import mdl_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF,
    localparam int IDX_W = $clog2(LINE_SIZE)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  step,
    output logic [IDX_W-1:0]      delay
);

    localparam int SUM_W = ((IDX_W > BASE_W) ? IDX_W : BASE_W) + 2;
    localparam logic signed [SUM_W-1:0] DLY_MAX = SUM_W'(LINE_SIZE - 1);
    localparam logic signed [SUM_W-1:0] DLY_MIN = SUM_W'(1);

    logic [BASE_W-1:0]          base_reg;
    logic [PERIOD_W-1:0]        period_reg;
    logic [DEPTH_W-1:0]         depth_reg;
    logic [PERIOD_W-1:0]        cnt_reg,    cnt_next;
    logic signed [OFFS_W-1:0]   offset_reg, offset_next;
    logic                       down_reg,   down_next;

    logic [OFFS_W-1:0]          mag;
    logic                       flip;
    logic                       cfg_hit;
    logic signed [SUM_W-1:0]    sum;

    // saturated base plus triangle offset
    always_comb
    begin
        sum = $signed({{(SUM_W-BASE_W){1'b0}}, base_reg})
            + $signed({{(SUM_W-OFFS_W){offset_reg[OFFS_W-1]}}, offset_reg});
        if (sum < DLY_MIN)
        begin
            delay = IDX_W'(1);
        end
        else if (sum > DLY_MAX)
        begin
            delay = DLY_MAX[IDX_W-1:0];
        end
        else
        begin
            delay = sum[IDX_W-1:0];
        end
    end

    // writes to an index that is not a register leave everything alone
    assign cfg_hit = cfg_we
                  && (cfg_index inside {REG_BASE_DELAY, REG_MOD_PERIOD, REG_MOD_DEPTH});

    always_comb
    begin
        mag         = offset_reg[OFFS_W-1] ? OFFS_W'(-offset_reg) : OFFS_W'(offset_reg);
        flip        = (mag == {1'b0, depth_reg});
        cnt_next    = cnt_reg;
        offset_next = offset_reg;
        down_next   = down_reg;
        if (cfg_hit)
        begin
            // any register write restarts the triangle
            offset_next = '0;
            down_next   = 1'b0;
            case (cfg_index)
                REG_MOD_PERIOD: cnt_next = cfg_data[PERIOD_W-1:0];
                default:        cnt_next = period_reg;
            endcase
        end
        else if (step && (depth_reg != '0))
        begin
            if (cnt_reg > PERIOD_W'(1))
            begin
                cnt_next = cnt_reg - PERIOD_W'(1);
            end
            else
            begin
                down_next   = down_reg ^ flip;
                offset_next = down_next ? offset_reg - OFFS_W'(1) : offset_reg + OFFS_W'(1);
                cnt_next    = period_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_W'(1);
            period_reg <= '0;
            depth_reg  <= '0;
            cnt_reg    <= '0;
            offset_reg <= '0;
            down_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            offset_reg <= offset_next;
            down_reg   <= down_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BASE_DELAY: base_reg   <= cfg_data[BASE_W-1:0];
                    REG_MOD_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                    REG_MOD_DEPTH:  depth_reg  <= cfg_data[DEPTH_W-1:0];
                    default:        base_reg   <= base_reg;
                endcase
            end
        end
    end

endmodule

>>> design/mdl_line.sv
module mdl_line
    import mdl_pkg::*;
#(
    parameter int LINE_SIZE   = LINE_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W = $clog2(LINE_SIZE)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic signed [SAMPLE_BITS-1:0] wr_sample,
    input  logic [IDX_W-1:0]              delay,
    output logic                          rd_valid,
    output logic signed [SAMPLE_BITS-1:0] rd_sample,
    output logic [IDX_W-1:0]              rd_delay
);

    logic [SAMPLE_BITS-1:0] mem [LINE_SIZE];

    logic [IDX_W-1:0]       wptr_reg;
    logic [IDX_W:0]         fill_reg;
    logic [IDX_W-1:0]       rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   valid_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       delay_reg;

    assign rd_addr = wptr_reg - delay;

    // delay never hits the write slot, so read and write never collide
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_sample;
            rd_data_reg   <= mem[rd_addr];
            delay_reg     <= delay;
            // slot written since reset only if it lies within the fill count
            hit_reg       <= ({1'b0, delay} <= fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= wr_en;
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + IDX_W'(1);
                if (fill_reg != (IDX_W+1)'(LINE_SIZE))
                begin
                    fill_reg <= fill_reg + (IDX_W+1)'(1);
                end
            end
        end
    end

    assign rd_valid  = valid_reg;
    assign rd_sample = hit_reg ? $signed(rd_data_reg) : '0;
    assign rd_delay  = delay_reg;

endmodule

>>> design/mdl_outq.sv
module mdl_outq
    import mdl_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int DELAY_W     = $clog2(LINE_SIZE_DEF)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] push_sample,
    input  logic [DELAY_W-1:0]            push_delay,
    output logic                          full_soon,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [DELAY_W-1:0]            delay_out
);

    logic signed [SAMPLE_BITS-1:0] q_sample_reg [OUTQ_DEPTH];
    logic [DELAY_W-1:0]            q_delay_reg  [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]         wptr_reg, rptr_reg;
    logic [OUTQ_CNT_W-1:0]         cnt_reg;
    logic                          pop;
    logic [OUTQ_CNT_W:0]           in_flight;

    function automatic logic [OUTQ_PTR_W-1:0] ptr_inc(input logic [OUTQ_PTR_W-1:0] p);
        ptr_inc = (p == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : p + OUTQ_PTR_W'(1);
    endfunction

    assign out_valid  = (cnt_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign sample_out = q_sample_reg[rptr_reg];
    assign delay_out  = q_delay_reg[rptr_reg];

    // room for the beat in the read stage plus one more, regardless of pop
    assign in_flight  = {1'b0, cnt_reg} + (OUTQ_CNT_W+1)'(push);
    assign full_soon  = (in_flight >= (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_sample_reg[wptr_reg] <= push_sample;
            q_delay_reg[wptr_reg]  <= push_delay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ptr_inc(wptr_reg);
            end
            if (pop)
            begin
                rptr_reg <= ptr_inc(rptr_reg);
            end
            cnt_reg <= cnt_reg + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
        end
    end

endmodule

>>> design/modulated_delay_line.sv
// Delay line with a triangle-modulated read tap. Takes one sample per clock while in_stall
// is low and returns one result per sample, passed through the line read register and then
// the output queue; the ring buffer is one memory with one write and one registered read
// port, both used once per sample, and that port pair sets the rate. A three-entry output
// queue lets the input keep flowing while a result waits. Slots not yet written since reset
// read as zero through a fill count, so there is no clearing pass after reset. Register
// writes (index 0 base_delay, 1 mod_period, 2 swing_depth, others ignored) are always ready
// and restart the modulation; write them only while the line is idle.
`include "modulated_delay_line_assert.svh"

module modulated_delay_line
    import mdl_pkg::*;
#(
    parameter int LINE_SIZE   = LINE_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int IDX_W = $clog2(LINE_SIZE)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [IDX_W-1:0]              delay_now,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    logic                          accept;
    logic [IDX_W-1:0]              delay;
    logic                          rd_valid;
    logic signed [SAMPLE_BITS-1:0] rd_sample;
    logic [IDX_W-1:0]              rd_delay;
    logic                          full_soon;

    assign cfg_ready = 1'b1;
    assign in_stall  = full_soon;
    assign accept    = in_valid && !in_stall;

    mdl_mod #(
        .LINE_SIZE (LINE_SIZE)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (accept),
        .delay     (delay)
    );

    mdl_line #(
        .LINE_SIZE   (LINE_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (accept),
        .wr_sample (sample_in),
        .delay     (delay),
        .rd_valid  (rd_valid),
        .rd_sample (rd_sample),
        .rd_delay  (rd_delay)
    );

    mdl_outq #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .DELAY_W     (IDX_W)
    ) u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (rd_valid),
        .push_sample (rd_sample),
        .push_delay  (rd_delay),
        .full_soon   (full_soon),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .delay_out   (delay_now)
    );

    // every accepted beat reaches the read stage next cycle
    `MDL_ASSERT_NXT(a_accept_reads, accept, rd_valid)
    // an empty output queue never holds off the input
    `MDL_ASSERT_IMP(a_empty_no_stall, !out_valid, !in_stall)
    // a delivered delay is never zero
    `MDL_ASSERT_IMP(a_delay_nonzero, out_valid, delay_now != '0)

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mdl_pkg::*;

    localparam int TAP_W           = $clog2(LINE_SIZE_DEF);
    localparam int HOLD_CYCLES     = 80;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 8;

    // index 3 is not a register, the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS_DEF-1:0] sample;
        logic [TAP_W-1:0]           delay;
    } tap_t;

    // predicts the tap read for every sample written and checks the returned beats
    class delay_tap_model;
        logic [SAMPLE_BITS_DEF-1:0] line_mem [LINE_SIZE_DEF];
        logic [TAP_W-1:0]           wr_ptr;
        logic [PERIOD_W-1:0]        step_count;
        int                         tri_offset;
        bit                         falling;
        logic [BASE_W-1:0]          base_delay;
        logic [PERIOD_W-1:0]        period;
        logic [DEPTH_W-1:0]         depth;
        tap_t                       pending_taps[$];
        int                         errors;
        int                         checked;

        function new();
            foreach (line_mem[i])
                line_mem[i] = '0;
            wr_ptr = '0;
            base_delay = 1;
            period = '0;
            depth = '0;
            errors = 0;
            checked = 0;
            restart_triangle();
        endfunction

        function void restart_triangle();
            step_count = period;
            tri_offset = 0;
            falling = 1'b0;
        endfunction

        function int pending();
            return pending_taps.size();
        endfunction

        function int tap_delay();
            int d;
            d = int'(base_delay) + tri_offset;
            if (d < 1)
                d = 1;
            if (d > LINE_SIZE_DEF - 1)
                d = LINE_SIZE_DEF - 1;
            return d;
        endfunction

        task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_BASE_DELAY: base_delay = value[BASE_W-1:0];
                REG_MOD_PERIOD: period = value[PERIOD_W-1:0];
                REG_MOD_DEPTH:  depth = value[DEPTH_W-1:0];
                default:        return;
            endcase
            restart_triangle();
        endtask

        task step_triangle();
            int mag;
            if (depth == 0)
                return;
            if (step_count > 1)
            begin
                step_count = step_count - 1'b1;
                return;
            end
            mag = (tri_offset < 0) ? -tri_offset : tri_offset;
            if (mag == int'(depth))
                falling = !falling;
            tri_offset = tri_offset + (falling ? -1 : 1);
            step_count = period;
        endtask

        task take_sample(input logic [SAMPLE_BITS_DEF-1:0] value);
            int               d;
            logic [TAP_W-1:0] rd_ptr;
            tap_t             t;
            d = tap_delay();
            rd_ptr = wr_ptr - d[TAP_W-1:0];
            t.sample = line_mem[rd_ptr];
            t.delay = d[TAP_W-1:0];
            pending_taps.push_back(t);
            line_mem[wr_ptr] = value;
            wr_ptr = wr_ptr + 1'b1;
            step_triangle();
        endtask

        task report_mismatch(input string what);
            errors++;
            $display("mismatch at beat %0d: %s", checked, what);
        endtask

        task check_tap(input logic [SAMPLE_BITS_DEF-1:0] sample, input logic [TAP_W-1:0] delay);
            tap_t want;
            checked++;
            if (pending_taps.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat, sample %h delay %0d", sample, delay));
                return;
            end
            want = pending_taps.pop_front();
            if (sample !== want.sample)
                report_mismatch($sformatf("sample_out %h, want %h", sample, want.sample));
            if (delay !== want.delay)
                report_mismatch($sformatf("delay_now %0d, want %0d", delay, want.delay));
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [SAMPLE_BITS_DEF-1:0] sample_in;
    logic                              out_valid;
    logic                              out_stall;
    logic signed [SAMPLE_BITS_DEF-1:0] sample_out;
    logic [TAP_W-1:0]                  delay_now;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [CFG_IDX_W-1:0]              cfg_index;
    logic [CFG_DATA_W-1:0]             cfg_data;

    delay_tap_model taps;
    int             gap_chance;
    int             stall_chance;
    bit             hold_off_req;
    int             quiet_cycles;

    modulated_delay_line dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .delay_now  (delay_now),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                taps.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                taps.take_sample(sample_in);
            if (out_valid && !out_stall)
                taps.check_tap(sample_out, delay_now);
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_chance != 0 && $urandom_range(1, 100) <= stall_chance)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_sample(input logic [SAMPLE_BITS_DEF-1:0] value);
        if (gap_chance != 0 && $urandom_range(1, 100) <= gap_chance)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_samples(input int count);
        repeat (count)
            send_sample(SAMPLE_BITS_DEF'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (taps.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] base,
                             input logic [CFG_DATA_W-1:0] period,
                             input logic [CFG_DATA_W-1:0] depth);
        write_reg(REG_BASE_DELAY, base);
        write_reg(REG_MOD_PERIOD, period);
        write_reg(REG_MOD_DEPTH, depth);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        taps = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_in = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_DELAY;
        cfg_data = '0;
        gap_chance = 20;
        stall_chance = 20;
        hold_off_req = 1'b0;
        quiet_cycles = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: fixed delay of one, field extremes and bit patterns
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);
        send_sample(24'h000000);
        send_sample(24'hFFFFFF);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        drain();

        // unused index ignored, base masks to zero, period zero steps every sample,
        // depth masks to three, so the delay clamps at one on the way down
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_BASE_DELAY, 16'hF800);
        write_reg(REG_MOD_PERIOD, 16'h0000);
        write_reg(REG_MOD_DEPTH, 16'hFF03);
        cfg_valid <= 1'b0;
        run_samples(10);
        drain();

        configure(2, 3, 2);
        run_samples(8);
        drain();

        // widest swing around the longest base delay
        configure(16'hFFFF, 1, 255);
        run_samples(120);
        drain();

        // short delays, the receiver holds off while the sender keeps offering
        configure(CFG_DATA_W'($urandom_range(1, 300)), CFG_DATA_W'($urandom_range(2, 8)),
                  CFG_DATA_W'($urandom_range(1, 20)));
        hold_off_req = 1'b1;
        run_samples(150);
        drain();

        // longest period, no idling on either side
        gap_chance = 0;
        stall_chance = 0;
        configure(5, 16'hFFFF, 255);
        run_samples(60);
        drain();

        gap_chance = 30;
        stall_chance = 30;
        configure(CFG_DATA_W'($urandom_range(0, 16'hFFFF)),
                  CFG_DATA_W'($urandom_range(0, 16'hFFFF)), 0);
        run_samples(100);
        drain();

        // base near zero so the negative half of the triangle clamps
        configure(CFG_DATA_W'($urandom_range(0, 3)), 2, 10);
        run_samples(150);
        drain();

        gap_chance = 15;
        stall_chance = 25;
        repeat (3)
        begin
            configure(CFG_DATA_W'($urandom_range(0, 2047)), CFG_DATA_W'($urandom_range(0, 12)),
                      CFG_DATA_W'($urandom_range(0, 255)));
            run_samples(60);
            drain();
        end

        gap_chance = 0;
        stall_chance = 0;
        configure(CFG_DATA_W'($urandom_range(1, 2047)), CFG_DATA_W'($urandom_range(0, 4)),
                  CFG_DATA_W'($urandom_range(1, 30)));
        run_samples(120);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (taps.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/mdl_pkg.sv
design/mdl_mod.sv
design/mdl_line.sv
design/mdl_outq.sv
design/modulated_delay_line.sv
bench/tb_top.sv
